/* hw/rtl/ttvs_pkg.sv */
// ttvs_pkg: field widths, operation codes and register indexes of the
// texture victim select block; no dependencies
package ttvs_pkg;

    localparam int OP_BITS        = 2;
    localparam int INDEX_BITS     = 8;
    localparam int OWNER_ID_BITS  = 10;
    localparam int PAINTER_BITS   = 8;
    localparam int SCALE_BITS     = 16;
    localparam int COUNT_BITS     = 32;
    localparam int SIZE_BITS      = 9;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_BITS-1:0] OP_GATHER  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_POOL_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAYER_POOL_SIZE = 2'd1;

endpackage

/* hw/rtl/ttvs_if.sv */
// ttvs_if: valid/ready channel interfaces for item, result and config beats
// depends on ttvs_pkg for field widths
interface ttvs_item_if;
    logic                               valid;
    logic                               ready;
    logic [ttvs_pkg::OP_BITS-1:0]       op;
    logic                               pool;
    logic [ttvs_pkg::INDEX_BITS-1:0]    entry_index;
    logic                               flag_bit;
    logic                               busy_bit;
    logic [ttvs_pkg::OWNER_ID_BITS-1:0] owner_id;
    logic [ttvs_pkg::PAINTER_BITS-1:0]  painter_id;
    logic [ttvs_pkg::SCALE_BITS-1:0]    scale_code;
    logic [ttvs_pkg::COUNT_BITS-1:0]    count_value;

    modport source (
        output valid, op, pool, entry_index, flag_bit, busy_bit, owner_id,
               painter_id, scale_code, count_value,
        input  ready
    );
    modport sink (
        input  valid, op, pool, entry_index, flag_bit, busy_bit, owner_id,
               painter_id, scale_code, count_value,
        output ready
    );
endinterface

interface ttvs_result_if;
    logic                               valid;
    logic                               ready;
    logic                               granted;
    logic [ttvs_pkg::INDEX_BITS-1:0]    granted_index;
    logic                               stolen;
    logic [ttvs_pkg::OWNER_ID_BITS-1:0] previous_owner;
    logic                               layers_remain;

    modport source (
        output valid, granted, granted_index, stolen, previous_owner, layers_remain,
        input  ready
    );
    modport sink (
        input  valid, granted, granted_index, stolen, previous_owner, layers_remain,
        output ready
    );
endinterface

interface ttvs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ttvs_pkg::CFG_INDEX_BITS-1:0] index;
    logic [ttvs_pkg::SIZE_BITS-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/ttvs_ram.sv */
// ttvs_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module ttvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/tile_texture_victim_select_unit.sv */
// tile_texture_victim_select_unit: two-pool texture victim selection with one
// entry ram scanned by a sequencer; depends on ttvs_pkg, ttvs_if, ttvs_ram
// request: back texture read and check, then a pool scan on a miss or no claim
// (one entry per cycle through the ram read port); gather: pool sweep;
// write: read then put. one item at a time, ready only between items
// reset: clearing pass zeroes all 2 * 2**clog2(POOL_DEPTH) rows; cfg always taken
module tile_texture_victim_select_unit #(
    parameter int POOL_DEPTH   = 256,
    parameter int TILE_ID_BITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    ttvs_item_if.sink     item,
    ttvs_result_if.source result,
    ttvs_cfg_if.sink      cfg
);

    localparam int IDX_W     = $clog2(POOL_DEPTH);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int CNT_W     = $clog2(POOL_DEPTH + 1);

    typedef struct packed {
        logic                                avail;
        logic                                busy;
        logic                                owned;
        logic [TILE_ID_BITS-1:0]             tile;
        logic [ttvs_pkg::PAINTER_BITS-1:0]   painter;
        logic [ttvs_pkg::SCALE_BITS-1:0]     scale;
        logic [ttvs_pkg::COUNT_BITS-1:0]     count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BACK_RD, S_BACK_CHK, S_SCAN, S_TAKE,
        S_GATHER, S_WR_RD, S_WR_PUT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]  proc_idx_reg, proc_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_idx_reg, pick_idx_next;
    entry_t            pick_entry_reg, pick_entry_next;
    logic [ttvs_pkg::COUNT_BITS:0] oldest_reg, oldest_next;
    logic              layers_reg, layers_next;
    logic [ttvs_pkg::SIZE_BITS-1:0] base_size_reg, base_size_next;
    logic [ttvs_pkg::SIZE_BITS-1:0] layer_size_reg, layer_size_next;

    logic                               req_pool_reg, req_pool_next;
    logic [ttvs_pkg::INDEX_BITS-1:0]    req_index_reg, req_index_next;
    logic                               req_flag_reg, req_flag_next;
    logic                               req_busy_reg, req_busy_next;
    logic [TILE_ID_BITS-1:0]            req_tile_reg, req_tile_next;
    logic [ttvs_pkg::PAINTER_BITS-1:0]  req_painter_reg, req_painter_next;
    logic [ttvs_pkg::SCALE_BITS-1:0]    req_scale_reg, req_scale_next;
    logic [ttvs_pkg::COUNT_BITS-1:0]    req_count_reg, req_count_next;

    logic                               res_granted_reg, res_granted_next;
    logic [ttvs_pkg::INDEX_BITS-1:0]    res_index_reg, res_index_next;
    logic                               res_stolen_reg, res_stolen_next;
    logic [ttvs_pkg::OWNER_ID_BITS-1:0] res_prev_reg, res_prev_next;

    logic                               out_valid_reg, out_valid_next;
    logic                               out_granted_reg, out_granted_next;
    logic [ttvs_pkg::INDEX_BITS-1:0]    out_index_reg, out_index_next;
    logic                               out_stolen_reg, out_stolen_next;
    logic [ttvs_pkg::OWNER_ID_BITS-1:0] out_prev_reg, out_prev_next;
    logic                               out_layers_reg, out_layers_next;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               scan_stop;
    logic               item_idx_ok;
    logic [IDX_W-1:0]   req_slot;
    logic [ttvs_pkg::SIZE_BITS-1:0] pool_size;

    ttvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry    = entry_t'(ram_rd_data);
    assign item_idx_ok = (32'(item.entry_index) < 32'(POOL_DEPTH));
    assign req_slot    = IDX_W'(req_index_reg);
    assign pool_size   = req_pool_reg ? layer_size_reg : base_size_reg;

    assign item.ready            = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.granted        = out_granted_reg;
    assign result.granted_index  = out_index_reg;
    assign result.stolen         = out_stolen_reg;
    assign result.previous_owner = out_prev_reg;
    assign result.layers_remain  = out_layers_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        issue_cnt_next   = issue_cnt_reg;
        proc_valid_next  = 1'b0;
        proc_idx_next    = proc_idx_reg;
        found_next       = found_reg;
        pick_idx_next    = pick_idx_reg;
        pick_entry_next  = pick_entry_reg;
        oldest_next      = oldest_reg;
        layers_next      = layers_reg;
        base_size_next   = base_size_reg;
        layer_size_next  = layer_size_reg;
        req_pool_next    = req_pool_reg;
        req_index_next   = req_index_reg;
        req_flag_next    = req_flag_reg;
        req_busy_next    = req_busy_reg;
        req_tile_next    = req_tile_reg;
        req_painter_next = req_painter_reg;
        req_scale_next   = req_scale_reg;
        req_count_next   = req_count_reg;
        res_granted_next = res_granted_reg;
        res_index_next   = res_index_reg;
        res_stolen_next  = res_stolen_reg;
        res_prev_next    = res_prev_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_index_next   = out_index_reg;
        out_stolen_next  = out_stolen_reg;
        out_prev_next    = out_prev_reg;
        out_layers_next  = out_layers_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = '0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;
        wr_entry         = rd_entry;
        scan_stop        = 1'b0;

        if (cfg.valid)
        begin
            if (cfg.index == ttvs_pkg::CFG_BASE_POOL_SIZE)
            begin
                base_size_next = cfg.data;
            end
            else if (cfg.index == ttvs_pkg::CFG_LAYER_POOL_SIZE)
            begin
                layer_size_next = cfg.data;
            end
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                wr_entry    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item.valid)
                begin
                    req_pool_next    = item.pool;
                    req_index_next   = item.entry_index;
                    req_flag_next    = item.flag_bit;
                    req_busy_next    = item.busy_bit;
                    req_tile_next    = TILE_ID_BITS'(item.owner_id);
                    req_painter_next = item.painter_id;
                    req_scale_next   = item.scale_code;
                    req_count_next   = item.count_value;
                    res_granted_next = 1'b0;
                    res_index_next   = '0;
                    res_stolen_next  = 1'b0;
                    res_prev_next    = '0;
                    issue_cnt_next   = '0;
                    found_next       = 1'b0;
                    pick_idx_next    = '0;
                    // zero frame count wraps so every draw count qualifies
                    oldest_next      = {1'b0, item.count_value} - 1'b1;
                    unique case (item.op)
                        ttvs_pkg::OP_REQUEST:
                        begin
                            if (item.flag_bit && item_idx_ok)
                            begin
                                state_next = S_BACK_RD;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ttvs_pkg::OP_GATHER:
                        begin
                            state_next = S_GATHER;
                        end
                        ttvs_pkg::OP_WRITE:
                        begin
                            state_next = item_idx_ok ? S_WR_RD : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_BACK_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = {req_pool_reg, req_slot};
                state_next  = S_BACK_CHK;
            end

            S_BACK_CHK:
            begin
                if (rd_entry.owned && rd_entry.tile == req_tile_reg)
                begin
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = {req_pool_reg, req_slot};
                    wr_entry.avail   = 1'b0;
                    res_granted_next = 1'b1;
                    res_index_next   = req_index_reg;
                    state_next       = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read of entry n overlaps the evaluation of entry n - 1
                if (issue_cnt_reg < CNT_W'(POOL_DEPTH))
                begin
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = {req_pool_reg, IDX_W'(issue_cnt_reg)};
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    proc_valid_next = 1'b1;
                    proc_idx_next   = IDX_W'(issue_cnt_reg);
                end
                if (proc_valid_reg && rd_entry.avail && !rd_entry.busy)
                begin
                    if (!rd_entry.owned)
                    begin
                        scan_stop = 1'b1;
                    end
                    else if (rd_entry.tile == req_tile_reg)
                    begin
                        scan_stop = 1'b0;
                    end
                    else if (rd_entry.painter == req_painter_reg &&
                             rd_entry.scale != req_scale_reg)
                    begin
                        scan_stop = 1'b1;
                    end
                    else if (oldest_reg > {1'b0, rd_entry.count})
                    begin
                        oldest_next     = {1'b0, rd_entry.count};
                        found_next      = 1'b1;
                        pick_idx_next   = proc_idx_reg;
                        pick_entry_next = rd_entry;
                    end
                end
                if (scan_stop)
                begin
                    found_next      = 1'b1;
                    pick_idx_next   = proc_idx_reg;
                    pick_entry_next = rd_entry;
                    proc_valid_next = 1'b0;
                    state_next      = S_TAKE;
                end
                else if (issue_cnt_reg == CNT_W'(POOL_DEPTH) && !proc_valid_reg)
                begin
                    state_next = S_TAKE;
                end
            end

            S_TAKE:
            begin
                if (found_reg)
                begin
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = {req_pool_reg, pick_idx_reg};
                    wr_entry         = pick_entry_reg;
                    wr_entry.avail   = 1'b0;
                    wr_entry.owned   = 1'b1;
                    wr_entry.tile    = req_tile_reg;
                    wr_entry.painter = req_painter_reg;
                    res_granted_next = 1'b1;
                    res_index_next   = ttvs_pkg::INDEX_BITS'(pick_idx_reg);
                    res_stolen_next  = pick_entry_reg.owned;
                    res_prev_next    = pick_entry_reg.owned ?
                                       ttvs_pkg::OWNER_ID_BITS'(pick_entry_reg.tile) : '0;
                end
                else if (req_pool_reg)
                begin
                    layers_next = 1'b0;
                end
                state_next = S_DONE;
            end

            S_GATHER:
            begin
                // read-modify-write sweep of the available marks
                if (issue_cnt_reg < CNT_W'(POOL_DEPTH))
                begin
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = {req_pool_reg, IDX_W'(issue_cnt_reg)};
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    proc_valid_next = 1'b1;
                    proc_idx_next   = IDX_W'(issue_cnt_reg);
                end
                if (proc_valid_reg)
                begin
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = {req_pool_reg, proc_idx_reg};
                    wr_entry.avail = (32'(proc_idx_reg) < 32'(pool_size));
                end
                else if (issue_cnt_reg == CNT_W'(POOL_DEPTH))
                begin
                    if (req_pool_reg)
                    begin
                        layers_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            S_WR_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = {req_pool_reg, req_slot};
                state_next  = S_WR_PUT;
            end

            S_WR_PUT:
            begin
                // available mark is kept, everything else comes from the beat
                ram_wr_en        = 1'b1;
                ram_wr_addr      = {req_pool_reg, req_slot};
                wr_entry.busy    = req_busy_reg;
                wr_entry.owned   = req_flag_reg;
                wr_entry.tile    = req_tile_reg;
                wr_entry.painter = req_painter_reg;
                wr_entry.scale   = req_scale_reg;
                wr_entry.count   = req_count_reg;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_index_next   = res_index_reg;
                    out_stolen_next  = res_stolen_reg;
                    out_prev_next    = res_prev_reg;
                    out_layers_next  = layers_reg;
                    state_next       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            issue_cnt_reg   <= '0;
            proc_valid_reg  <= 1'b0;
            proc_idx_reg    <= '0;
            found_reg       <= 1'b0;
            pick_idx_reg    <= '0;
            pick_entry_reg  <= '0;
            oldest_reg      <= '0;
            layers_reg      <= 1'b1;
            base_size_reg   <= '0;
            layer_size_reg  <= '0;
            req_pool_reg    <= 1'b0;
            req_index_reg   <= '0;
            req_flag_reg    <= 1'b0;
            req_busy_reg    <= 1'b0;
            req_tile_reg    <= '0;
            req_painter_reg <= '0;
            req_scale_reg   <= '0;
            req_count_reg   <= '0;
            res_granted_reg <= 1'b0;
            res_index_reg   <= '0;
            res_stolen_reg  <= 1'b0;
            res_prev_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_granted_reg <= 1'b0;
            out_index_reg   <= '0;
            out_stolen_reg  <= 1'b0;
            out_prev_reg    <= '0;
            out_layers_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            issue_cnt_reg   <= issue_cnt_next;
            proc_valid_reg  <= proc_valid_next;
            proc_idx_reg    <= proc_idx_next;
            found_reg       <= found_next;
            pick_idx_reg    <= pick_idx_next;
            pick_entry_reg  <= pick_entry_next;
            oldest_reg      <= oldest_next;
            layers_reg      <= layers_next;
            base_size_reg   <= base_size_next;
            layer_size_reg  <= layer_size_next;
            req_pool_reg    <= req_pool_next;
            req_index_reg   <= req_index_next;
            req_flag_reg    <= req_flag_next;
            req_busy_reg    <= req_busy_next;
            req_tile_reg    <= req_tile_next;
            req_painter_reg <= req_painter_next;
            req_scale_reg   <= req_scale_next;
            req_count_reg   <= req_count_next;
            res_granted_reg <= res_granted_next;
            res_index_reg   <= res_index_next;
            res_stolen_reg  <= res_stolen_next;
            res_prev_reg    <= res_prev_next;
            out_valid_reg   <= out_valid_next;
            out_granted_reg <= out_granted_next;
            out_index_reg   <= out_index_next;
            out_stolen_reg  <= out_stolen_next;
            out_prev_reg    <= out_prev_next;
            out_layers_reg  <= out_layers_next;
        end
    end

endmodule

/* dv/tb_tile_texture_victim_select_unit.sv */
`timescale 1ns / 100ps
// tb_tile_texture_victim_select_unit: self-checking bench for the texture victim select unit,
// with a scoreboard class that predicts every result beat from the accepted item beats
// depends on ttvs_pkg, ttvs_if and tile_texture_victim_select_unit

import ttvs_pkg::*;

localparam int                 POOL_ENTRIES = 256;
localparam logic [OP_BITS-1:0] OP_UNUSED    = 2'd3;

typedef struct {
    logic [OP_BITS-1:0]       op;
    logic                     pool;
    logic [INDEX_BITS-1:0]    entry_index;
    logic                     flag_bit;
    logic                     busy_bit;
    logic [OWNER_ID_BITS-1:0] owner_id;
    logic [PAINTER_BITS-1:0]  painter_id;
    logic [SCALE_BITS-1:0]    scale_code;
    logic [COUNT_BITS-1:0]    count_value;
} tex_item_t;

typedef struct {
    logic                     granted;
    logic [INDEX_BITS-1:0]    granted_index;
    logic                     stolen;
    logic [OWNER_ID_BITS-1:0] previous_owner;
    logic                     layers_remain;
} tex_grant_t;

class victim_scoreboard;
    bit                     avail   [2*POOL_ENTRIES];
    bit                     busy    [2*POOL_ENTRIES];
    bit                     owned   [2*POOL_ENTRIES];
    bit [OWNER_ID_BITS-1:0] owner   [2*POOL_ENTRIES];
    bit [PAINTER_BITS-1:0]  painter [2*POOL_ENTRIES];
    bit [SCALE_BITS-1:0]    scale   [2*POOL_ENTRIES];
    bit [COUNT_BITS-1:0]    drawn   [2*POOL_ENTRIES];
    bit                     layers_left;
    bit [SIZE_BITS-1:0]     pool_size [2];
    tex_grant_t             grants_due [$];
    int                     errors;
    int                     checked;
    int                     requests;
    int                     hits;
    int                     grants;
    int                     steals;

    function new();
        layers_left = 1'b1;
    endfunction

    function void set_size(logic [CFG_INDEX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
        if (idx == CFG_BASE_POOL_SIZE)
            pool_size[0] = val;
        else if (idx == CFG_LAYER_POOL_SIZE)
            pool_size[1] = val;
    endfunction

    function void note_item(tex_item_t it);
        tex_grant_t          g;
        int                  base;
        int                  slot;
        int                  s;
        int                  i;
        int                  pick;
        int                  lim;
        bit                  found;
        logic [COUNT_BITS:0] oldest;
        g = '{default: '0};
        base = it.pool ? POOL_ENTRIES : 0;
        slot = base + int'(it.entry_index);
        if (it.op == OP_REQUEST) begin
            requests++;
            if (it.flag_bit && owned[slot] && owner[slot] == it.owner_id) begin
                avail[slot] = 1'b0;
                g.granted = 1'b1;
                g.granted_index = it.entry_index;
                hits++;
            end
            else begin
                // zero frame count wraps, so every draw count qualifies
                oldest = {1'b0, it.count_value} - 1'b1;
                found = 1'b0;
                pick = 0;
                for (i = 0; i < POOL_ENTRIES; i++) begin
                    s = base + i;
                    if (!avail[s] || busy[s])
                        continue;
                    if (!owned[s]) begin
                        pick = i;
                        found = 1'b1;
                        break;
                    end
                    if (owner[s] == it.owner_id)
                        continue;
                    if (painter[s] == it.painter_id && scale[s] != it.scale_code) begin
                        pick = i;
                        found = 1'b1;
                        break;
                    end
                    if (oldest > {1'b0, drawn[s]}) begin
                        oldest = {1'b0, drawn[s]};
                        pick = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    s = base + pick;
                    g.granted = 1'b1;
                    g.granted_index = INDEX_BITS'(pick);
                    if (owned[s]) begin
                        g.stolen = 1'b1;
                        g.previous_owner = owner[s];
                        steals++;
                    end
                    avail[s] = 1'b0;
                    owned[s] = 1'b1;
                    owner[s] = it.owner_id;
                    painter[s] = it.painter_id;
                end
                else if (it.pool) begin
                    layers_left = 1'b0;
                end
            end
            if (g.granted)
                grants++;
        end
        else if (it.op == OP_GATHER) begin
            lim = (pool_size[it.pool] > POOL_ENTRIES) ? POOL_ENTRIES : int'(pool_size[it.pool]);
            for (i = 0; i < POOL_ENTRIES; i++)
                avail[base + i] = (i < lim);
            if (it.pool)
                layers_left = 1'b1;
        end
        else if (it.op == OP_WRITE) begin
            owned[slot] = it.flag_bit;
            busy[slot] = it.busy_bit;
            owner[slot] = it.owner_id;
            painter[slot] = it.painter_id;
            scale[slot] = it.scale_code;
            drawn[slot] = it.count_value;
        end
        g.layers_remain = layers_left;
        grants_due.push_back(g);
    endfunction

    function void check_result(tex_grant_t got);
        tex_grant_t want;
        if (grants_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: result beat with nothing expected: granted %0d index %0d",
                         $realtime, got.granted, got.granted_index);
            return;
        end
        want = grants_due.pop_front();
        checked++;
        if (got.granted !== want.granted || got.granted_index !== want.granted_index ||
            got.stolen !== want.stolen || got.previous_owner !== want.previous_owner ||
            got.layers_remain !== want.layers_remain) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: mismatch on result beat %0d", $realtime, checked);
                $display("    expected granted %0d index %0d stolen %0d prev %0d layers %0d",
                         want.granted, want.granted_index, want.stolen, want.previous_owner,
                         want.layers_remain);
                $display("    actual   granted %0d index %0d stolen %0d prev %0d layers %0d",
                         got.granted, got.granted_index, got.stolen, got.previous_owner,
                         got.layers_remain);
            end
        end
    endfunction
endclass

module tb_tile_texture_victim_select_unit;

    localparam int    CLK_PERIOD      = 12;
    localparam int    PHASES          = 8;
    localparam int    ITEMS_PER_PHASE = 204;
    localparam longint TIMEOUT_CYCLES = 3_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   sender_idle_pct;
    int   stall_pct;

    victim_scoreboard sb = new();

    ttvs_item_if   item_bus ();
    ttvs_result_if result_bus ();
    ttvs_cfg_if    cfg_bus ();

    tile_texture_victim_select_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic tex_item_t make_item(
        input logic [OP_BITS-1:0]       op,
        input logic                     pool,
        input logic [INDEX_BITS-1:0]    idx,
        input logic                     flag,
        input logic                     busy,
        input logic [OWNER_ID_BITS-1:0] tile,
        input logic [PAINTER_BITS-1:0]  painter,
        input logic [SCALE_BITS-1:0]    scale,
        input logic [COUNT_BITS-1:0]    count
    );
        tex_item_t it;
        it.op = op;
        it.pool = pool;
        it.entry_index = idx;
        it.flag_bit = flag;
        it.busy_bit = busy;
        it.owner_id = tile;
        it.painter_id = painter;
        it.scale_code = scale;
        it.count_value = count;
        return it;
    endfunction

    // small value sets so owners, painters and scales collide often
    function automatic logic [OWNER_ID_BITS-1:0] pick_tile();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return OWNER_ID_BITS'($urandom_range(7));
        if (r < 80)
            return '1;
        return OWNER_ID_BITS'($urandom);
    endfunction

    function automatic logic [PAINTER_BITS-1:0] pick_painter();
        if ($urandom_range(99) < 75)
            return PAINTER_BITS'($urandom_range(3));
        return PAINTER_BITS'($urandom);
    endfunction

    function automatic logic [SCALE_BITS-1:0] pick_scale();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return SCALE_BITS'($urandom_range(3));
        if (r < 70)
            return '1;
        return SCALE_BITS'($urandom);
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return COUNT_BITS'($urandom_range(24));
        if (r < 80)
            return '0;
        if (r < 85)
            return '1;
        return COUNT_BITS'($urandom);
    endfunction

    function automatic tex_item_t random_item();
        tex_item_t it;
        int        r;
        int        slot;
        r = $urandom_range(99);
        it = make_item(OP_REQUEST, 1'($urandom_range(1)), INDEX_BITS'($urandom_range(15)),
                       1'($urandom_range(1)), ($urandom_range(99) < 25), pick_tile(),
                       pick_painter(), pick_scale(), pick_count());
        if (r < 4) begin
            // noise: every field at random
            it = make_item(OP_BITS'($urandom_range(3)), 1'($urandom_range(1)),
                           INDEX_BITS'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                           OWNER_ID_BITS'($urandom), PAINTER_BITS'($urandom),
                           SCALE_BITS'($urandom), COUNT_BITS'($urandom));
        end
        else if (r < 7) begin
            it.op = OP_UNUSED;
        end
        else if (r < 16) begin
            it.op = OP_GATHER;
        end
        else if (r < 46) begin
            it.op = OP_WRITE;
            if ($urandom_range(4) == 0)
                it.entry_index = INDEX_BITS'($urandom);
        end
        else begin
            // half of the back texture claims name the real owner
            if (it.flag_bit && $urandom_range(1)) begin
                slot = (it.pool ? POOL_ENTRIES : 0) + int'(it.entry_index);
                if (sb.owned[slot])
                    it.owner_id = sb.owner[slot];
            end
            if ($urandom_range(9) == 0)
                it.entry_index = INDEX_BITS'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(input tex_item_t it);
        int gap;
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge clk);
                item_bus.valid <= 1'b0;
            end
        end
        @(negedge clk);
        item_bus.valid       <= 1'b1;
        item_bus.op          <= it.op;
        item_bus.pool        <= it.pool;
        item_bus.entry_index <= it.entry_index;
        item_bus.flag_bit    <= it.flag_bit;
        item_bus.busy_bit    <= it.busy_bit;
        item_bus.owner_id    <= it.owner_id;
        item_bus.painter_id  <= it.painter_id;
        item_bus.scale_code  <= it.scale_code;
        item_bus.count_value <= it.count_value;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        sb.note_item(it);
    endtask

    // drop valid so the last beat is not taken twice, then wait for all results
    task automatic wait_drained();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (sb.grants_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [SIZE_BITS-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        sb.set_size(idx, val);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_directed();
        write_size(CFG_BASE_POOL_SIZE, 9'd4);
        write_size(CFG_LAYER_POOL_SIZE, 9'd2);
        // nothing available yet; the layer miss clears layers_remain
        send_item(make_item(OP_REQUEST, 1'b0, 8'd0, 1'b0, 1'b0, 10'd1, 8'd0, 16'd0, 32'd5));
        send_item(make_item(OP_REQUEST, 1'b1, 8'd0, 1'b0, 1'b0, 10'd1, 8'd0, 16'd0, 32'd5));
        send_item(make_item(OP_GATHER, 1'b1, 8'd0, 1'b0, 1'b0, 10'd0, 8'd0, 16'd0, 32'd0));
        send_item(make_item(OP_GATHER, 1'b0, 8'd0, 1'b0, 1'b0, 10'd0, 8'd0, 16'd0, 32'd0));
        send_item(make_item(OP_WRITE, 1'b0, 8'd0, 1'b1, 1'b0, 10'd5, 8'd1, 16'h0010, 32'd10));
        send_item(make_item(OP_WRITE, 1'b0, 8'd1, 1'b0, 1'b1, 10'd0, 8'd0, 16'd0, 32'd0));
        send_item(make_item(OP_WRITE, 1'b0, 8'd2, 1'b1, 1'b0, 10'd7, 8'd2, 16'hFFFF, 32'd3));
        send_item(make_item(OP_WRITE, 1'b0, 8'd3, 1'b1, 1'b0, 10'd9, 8'd1, 16'd0, '1));
        // self-owned skipped, busy skipped, oldest draw count taken
        send_item(make_item(OP_REQUEST, 1'b0, 8'd0, 1'b0, 1'b0, 10'd5, 8'd2, 16'hFFFF, 32'd20));
        // back texture still owned
        send_item(make_item(OP_REQUEST, 1'b0, 8'd2, 1'b1, 1'b0, 10'd5, 8'd0, 16'd0, 32'd0));
        // zero frame count, same painter with other scale wins
        send_item(make_item(OP_REQUEST, 1'b0, 8'd0, 1'b0, 1'b0, '1, 8'd1, 16'h0010, 32'd0));
        send_item(make_item(OP_WRITE, 1'b0, 8'd1, 1'b0, 1'b0, 10'd0, 8'd0, 16'd0, 32'd0));
        send_item(make_item(OP_REQUEST, 1'b0, 8'd0, 1'b0, 1'b0, 10'd0, 8'd0, 16'd0, 32'd5));
        send_item(make_item(OP_UNUSED, 1'b1, '1, 1'b1, 1'b1, '1, '1, '1, '1));
        send_item(make_item(OP_WRITE, 1'b1, 8'd0, 1'b1, 1'b0, 10'd0, '1, 16'd1, 32'd1));
        send_item(make_item(OP_REQUEST, 1'b1, 8'd0, 1'b0, 1'b0, 10'd1, 8'd0, 16'd0, 32'd1));
        send_item(make_item(OP_REQUEST, 1'b1, 8'd0, 1'b0, 1'b0, 10'd1, 8'd0, 16'd0, 32'd1));
        send_item(make_item(OP_REQUEST, 1'b1, 8'd0, 1'b0, 1'b0, 10'd1, 8'd0, 16'd0, '1));
        send_item(make_item(OP_GATHER, 1'b1, 8'd0, 1'b0, 1'b0, 10'd0, 8'd0, 16'd0, 32'd0));
        send_item(make_item(OP_WRITE, 1'b1, '1, 1'b1, 1'b1, '1, '1, '1, '1));
        send_item(make_item(OP_WRITE, 1'b0, 8'd0, 1'b0, 1'b0, 10'd0, 8'd0, 16'd0, 32'd0));
        // back texture hit on an entry that is not in the available set
        send_item(make_item(OP_REQUEST, 1'b1, '1, 1'b1, 1'b0, '1, 8'd0, 16'd0, 32'd0));
        send_item(make_item(OP_REQUEST, 1'b0, 8'd0, 1'b1, 1'b0, 10'd0, 8'd0, 16'd0, 32'd0));
        wait_drained();
    endtask

    initial begin
        result_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            sb.check_result(tex_grant_t'{result_bus.granted, result_bus.granted_index,
                                         result_bus.stolen, result_bus.previous_owner,
                                         result_bus.layers_remain});
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout with %0d result beats outstanding", $realtime,
                 sb.grants_due.size());
        $display("tb_tile_texture_victim_select_unit: errors");
        $finish;
    end

    initial begin
        int base_sizes  [PHASES];
        int layer_sizes [PHASES];
        int ph;
        int n;
        base_sizes  = '{0, 256, 16, 511, 1, 8, 300, 0};
        layer_sizes = '{256, 0, 511, 16, 8, 1, 0, 256};
        base_sizes[7]  = $urandom_range(511);
        layer_sizes[6] = $urandom_range(511);

        item_bus.valid       = 1'b0;
        item_bus.op          = OP_REQUEST;
        item_bus.pool        = 1'b0;
        item_bus.entry_index = '0;
        item_bus.flag_bit    = 1'b0;
        item_bus.busy_bit    = 1'b0;
        item_bus.owner_id    = '0;
        item_bus.painter_id  = '0;
        item_bus.scale_code  = '0;
        item_bus.count_value = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_BASE_POOL_SIZE;
        cfg_bus.data         = '0;
        sender_idle_pct      = 0;
        stall_pct            = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 53; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 53; end
                default: begin sender_idle_pct = 9; stall_pct = 9; end
            endcase
            write_size(CFG_BASE_POOL_SIZE, SIZE_BITS'(base_sizes[ph]));
            write_size(CFG_LAYER_POOL_SIZE, SIZE_BITS'(layer_sizes[ph]));
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // mid-phase hold-off until the unit has answered everything
                if (n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_item(random_item());
            end
            wait_drained();
        end

        stall_pct = 0;
        repeat (300) @(posedge clk);

        $display("covered %0d requests (%0d back texture hits, %0d grants, %0d steals)",
                 sb.requests, sb.hits, sb.grants, sb.steals);
        $display("%0d result beats checked over %0d pool size settings, %0d mismatches",
                 sb.checked, PHASES + 1, sb.errors);
        if (sb.errors == 0 && sb.grants_due.size() == 0)
            $display("tb_tile_texture_victim_select_unit: clean");
        else
            $display("tb_tile_texture_victim_select_unit: errors");
        $finish;
    end

endmodule
